// File: src/gsct_pkg.sv
// Shared types, codes and reset values for the geared sleep countdown timer.
package gsct_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_TIMER = 2'd1,
    REQ_OTHER = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_TICK_LIMIT = 2'd0;
  localparam logic [1:0] REG_MAX_GEAR   = 2'd1;
  localparam logic [1:0] REG_FIRST_MIN  = 2'd2;

  // Register reset values
  localparam logic [7:0] TICK_LIMIT_RST = 8'd99;
  localparam logic [3:0] MAX_GEAR_RST   = 4'd10;
  localparam logic [5:0] FIRST_MIN_RST  = 6'd30;

  // Reload value for seconds and minutes on a borrow
  localparam logic [5:0] SIXTY_MINUS_ONE = 6'd59;

  // Display codes
  localparam logic [3:0] DISP_NUM_GEAR_ONE = 4'd3;
  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_H    = 2'd1;
  localparam logic [1:0] SYM_F    = 2'd2;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] tick_limit;
    logic [3:0] max_gear;
    logic [5:0] first_gear_minutes;
  } cfg_t;

  // One result word, first field in the highest bits
  typedef struct packed {
    logic [1:0] disp_symbol;
    logic [3:0] disp_number;
    logic       expired;
    logic       wake_request;
    logic [5:0] seconds_left;
    logic [5:0] minutes_left;
    logic [3:0] hours_left;
    logic       running;
    logic [3:0] gear;
  } result_t;

endpackage

// File: src/gsct_regs.sv
// APB-style configuration registers of the sleep timer.
module gsct_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gsct_pkg::cfg_t     cfg
);
  import gsct_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_limit         <= TICK_LIMIT_RST;
      cfg.max_gear           <= MAX_GEAR_RST;
      cfg.first_gear_minutes <= FIRST_MIN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_LIMIT: cfg.tick_limit         <= pwdata[7:0];
        REG_MAX_GEAR:   cfg.max_gear           <= pwdata[3:0];
        REG_FIRST_MIN:  cfg.first_gear_minutes <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_TICK_LIMIT: prdata = {24'd0, cfg.tick_limit};
      REG_MAX_GEAR:   prdata = {28'd0, cfg.max_gear};
      REG_FIRST_MIN:  prdata = {26'd0, cfg.first_gear_minutes};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// File: src/gsct_core.sv
// Timer state and the single-pass update applied to each accepted word.
module gsct_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          req_type,
  input  logic                awake,
  input  logic                error_present,
  input  gsct_pkg::cfg_t      cfg,
  output gsct_pkg::result_t   result
);
  import gsct_pkg::*;

  logic [3:0] gear_reg, gear_reg_next;
  logic       run_flag, run_flag_next;
  logic [7:0] tick_count, tick_count_next;
  logic [5:0] sec_count, sec_count_next;
  logic [5:0] min_count, min_count_next;
  logic [3:0] hour_count, hour_count_next;
  logic       last_key_timer, last_key_timer_next;
  logic       wake, expired;
  logic [7:0] tick_inc;
  logic [4:0] gear_step;
  logic       repeat_press;
  req_t       req;

  assign req = req_t'(req_type);

  // Hold state until a word is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      gear_reg       <= '0;
      run_flag       <= 1'b0;
      tick_count     <= '0;
      sec_count      <= '0;
      min_count      <= '0;
      hour_count     <= '0;
      last_key_timer <= 1'b0;
    end else if (accept) begin
      gear_reg       <= gear_reg_next;
      run_flag       <= run_flag_next;
      tick_count     <= tick_count_next;
      sec_count      <= sec_count_next;
      min_count      <= min_count_next;
      hour_count     <= hour_count_next;
      last_key_timer <= last_key_timer_next;
    end
  end

  assign tick_inc  = tick_count + 8'd1;
  assign gear_step = {1'b0, gear_reg} + 5'd1;
  // A wake from standby counts as a first press
  assign repeat_press = awake && last_key_timer;

  // Work out the next state for this word
  always_comb begin
    gear_reg_next       = gear_reg;
    run_flag_next       = run_flag;
    tick_count_next     = tick_count;
    sec_count_next      = sec_count;
    min_count_next      = min_count;
    hour_count_next     = hour_count;
    last_key_timer_next = last_key_timer;
    wake                = 1'b0;
    expired             = 1'b0;
    case (req)
      REQ_TICK: begin
        if (run_flag) begin
          if (tick_inc > cfg.tick_limit) begin
            tick_count_next = '0;
            // Count down with borrow
            if (sec_count != '0) begin
              sec_count_next = sec_count - 6'd1;
            end else if (min_count != '0) begin
              min_count_next = min_count - 6'd1;
              sec_count_next = SIXTY_MINUS_ONE;
            end else if (hour_count != '0) begin
              hour_count_next = hour_count - 4'd1;
              min_count_next  = SIXTY_MINUS_ONE;
              sec_count_next  = SIXTY_MINUS_ONE;
            end else begin
              expired       = 1'b1;
              run_flag_next = 1'b0;
              gear_reg_next = '0;
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      REQ_TIMER: begin
        wake = !awake;
        if (awake || !error_present) begin
          last_key_timer_next = 1'b1;
          if (repeat_press || gear_reg == '0) begin
            run_flag_next = 1'b0;
            if (gear_step > {1'b0, cfg.max_gear}) begin
              // Past the top gear: switch the timer off
              gear_reg_next       = '0;
              sec_count_next      = '0;
              min_count_next      = '0;
              hour_count_next     = '0;
              last_key_timer_next = 1'b0;
            end else begin
              gear_reg_next = gear_step[3:0];
              if (gear_step[3:0] == 4'd1) begin
                min_count_next  = cfg.first_gear_minutes;
                hour_count_next = '0;
              end else begin
                hour_count_next = gear_reg;
                min_count_next  = '0;
              end
              sec_count_next  = '0;
              tick_count_next = '0;
              run_flag_next   = 1'b1;
            end
          end
        end
      end
      REQ_OTHER: last_key_timer_next = 1'b0;
      default: ;
    endcase
  end

  // Build the result from the updated state
  always_comb begin
    result.gear         = gear_reg_next;
    result.running      = run_flag_next;
    result.hours_left   = hour_count_next;
    result.minutes_left = min_count_next;
    result.seconds_left = sec_count_next;
    result.wake_request = wake;
    result.expired      = expired;
    if (gear_reg_next == '0) begin
      result.disp_number = '0;
      result.disp_symbol = SYM_F;
    end else if (gear_reg_next == 4'd1) begin
      result.disp_number = DISP_NUM_GEAR_ONE;
      result.disp_symbol = SYM_ZERO;
    end else begin
      result.disp_number = gear_reg_next - 4'd1;
      result.disp_symbol = SYM_H;
    end
  end

endmodule

// File: src/geared_sleep_countdown_timer.sv
// Top level of the geared sleep countdown timer: stream channels and result register.
//
// Input stream: one word per event. s_axis_tuser gives the kind (tick, timer
// key, other key); s_axis_tdata carries the awake and error flags. Every
// accepted word yields exactly one result word on the output stream, holding
// the gear, run flag, remaining time, wake and expiry pulses and the display
// code.
// Configuration: three APB registers (tick limit, top gear, first-gear
// minutes) at byte addresses 0, 4 and 8; write them only while idle.
// Timing: the result of a word is registered and appears on m_axis in the cycle after
// it is accepted. Throughput: one word per cycle unless the output stalls; the whole
// update is one pass of logic from the state registers into the result register.
// Stalls: while a result waits in the output register and m_axis_tready is
// low, s_axis_tready drops; input is taken again in the cycle the result
// leaves, so no word is lost or repeated.
// Reset: rst (synchronous, active high) clears the gear, counters and output
// valid, and sets the registers to 99, 10 and 30.
module geared_sleep_countdown_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] awake, [1] error_present, [7:2] zero
  input  logic [7:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] gear, [4] running, [8:5] hours_left, [14:9] minutes_left,
  // [20:15] seconds_left, [21] wake_request, [22] expired,
  // [26:23] disp_number, [28:27] disp_symbol, [31:29] zero
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gsct_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_word;
  logic    accept;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  gsct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsct_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req_type      (s_axis_tuser),
    .awake         (s_axis_tdata[0]),
    .error_present (s_axis_tdata[1]),
    .cfg           (cfg),
    .result        (result)
  );

  // Advance the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // Capture the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = {3'd0, out_word};

endmodule
